// ===== rtl/ape_pkg.sv =====
// Shared types, constants and helper functions for the array permute engine.
`default_nettype none

package ape_pkg;

	localparam int DEPTH  = 64;
	localparam int CNT_W  = 7;
	localparam int DATA_W = 32;
	localparam int FUNC_W = 3;
	localparam int STAT_W = 2;

	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [DATA_W-1:0] word_t;

	typedef enum logic [FUNC_W-1:0] {
		FN_APPEND  = 3'd0,
		FN_REVERSE = 3'd1,
		FN_PAIR    = 3'd2,
		FN_ROTATE  = 3'd3,
		FN_SPLIT   = 3'd4,
		FN_READ    = 3'd5
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_BAD_SPLIT = 2'd2,
		ST_BAD_INDEX = 2'd3
	} status_t;

	// What every cell does in the current cycle.
	typedef enum logic [2:0] {
		CM_HOLD,
		CM_APPEND,
		CM_NET,
		CM_PAIR,
		CM_READ
	} cell_mode_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_RUN,
		FSM_FINISH
	} fsm_t;

	// Broadcast from the sequencer to the row of cells.
	typedef struct packed {
		cell_mode_t mode;
		cnt_t       cnt;
		cnt_t       split;
		cnt_t       rnd;
		cnt_t       sel;
		word_t      value;
	} cell_ctl_t;

	// True when the cell at idx is the left member of a pair that swaps in
	// round rnd of the transposition network. The array is cut at split into
	// two ranges; each range is reversed by as many alternating rounds as it
	// has entries, with parity taken from the start of the range.
	function automatic logic net_is_left(input cnt_t idx, input cnt_t split,
		input cnt_t cnt, input cnt_t rnd);
		cnt_t nxt;
		logic res;
		nxt = idx + CNT_W'(1);
		res = 1'b0;
		if (nxt < split) begin
			res = (idx[0] == rnd[0]) && (rnd < split);
		end else if ((idx >= split) && (nxt < cnt)) begin
			res = ((idx[0] ^ split[0]) == rnd[0]) && (rnd < cnt - split);
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/array_permute_engine_top.sv =====
// Top level of the array permute engine: sequencer plus a row of storage cells.
`default_nettype none

// The engine keeps up to 64 signed 32-bit entries in a row of cells, one entry
// per cell, plus a fill count. Each input transaction performs one operation
// (append, reverse, pair swap, rotate right by one, split reverse or read) and
// yields exactly one output transaction carrying the read word (zero unless a
// read), the fill count afterward and a status code. Reordering is done by
// neighbor exchanges only: a reverse of n entries runs n rounds of alternating
// odd/even adjacent swaps, a split reverse runs both parts at once for the
// longer part's length, a pair swap is one round, and a rotate walks the last
// entry to the front with n-1 single swaps. A read moves the chosen entry to
// cell zero through a registered tap chain, one cell per cycle. A transaction
// passes from the idle state, where it is accepted and decoded, through a run
// state that steps the exchange rounds, to a finish state that updates the fill
// count and loads the output register; a rotate of fewer than two entries and
// any rejected or ignored operation skip the run state. One transaction is in
// flight at a time; a finished result sits in an output register so that the
// next transaction can start before it is taken.
// Entries that were never written hold unknown data, but only entries below
// the fill count are ever observed.

module array_permute_engine_top (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire [ape_pkg::FUNC_W-1:0]         func,
	input  wire signed [ape_pkg::DATA_W-1:0]  value,
	input  wire [ape_pkg::CNT_W-1:0]          position,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic signed [ape_pkg::DATA_W-1:0] read_value,
	output logic [ape_pkg::CNT_W-1:0]         fill_count,
	output logic [ape_pkg::STAT_W-1:0]        status
);
	import ape_pkg::*;

	cell_ctl_t ctl;
	word_t     cell_data [DEPTH];
	word_t     cell_tap  [DEPTH];

	// The sequencer owns the fill count and the output register.
	ape_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.value      (value),
		.position   (position),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_value (read_value),
		.fill_count (fill_count),
		.status     (status),
		.tap_head   (cell_tap[0]),
		.ctl        (ctl)
	);

	// Row of cells; each cell sees only its two neighbors. Cells at the ends
	// get zero where a neighbor is missing, and never select it.
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		word_t left_w;
		word_t right_w;
		word_t tap_w;

		if (k == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_inner_l
			assign left_w = cell_data[k-1];
		end

		if (k == DEPTH - 1) begin : g_last
			assign right_w = '0;
			assign tap_w   = '0;
		end else begin : g_inner_r
			assign right_w = cell_data[k+1];
			assign tap_w   = cell_tap[k+1];
		end

		ape_cell u_cell (
			.clk        (clk),
			.idx        (CNT_W'(k)),
			.ctl        (ctl),
			.left_data  (left_w),
			.right_data (right_w),
			.tap_in     (tap_w),
			.data       (cell_data[k]),
			.tap        (cell_tap[k])
		);
	end

endmodule

`default_nettype wire

// ===== rtl/ape_cell.sv =====
// One storage cell of the array: holds an entry and a read tap stage.
`default_nettype none

module ape_cell (
	input  wire                clk,
	input  ape_pkg::cnt_t      idx,
	input  ape_pkg::cell_ctl_t ctl,
	input  ape_pkg::word_t     left_data,
	input  ape_pkg::word_t     right_data,
	input  ape_pkg::word_t     tap_in,
	output ape_pkg::word_t     data,
	output ape_pkg::word_t     tap
);
	import ape_pkg::*;

	word_t data_q;
	word_t tap_q;
	logic  take_l;
	logic  take_r;

	always_comb begin
		take_l = 1'b0;
		take_r = 1'b0;
		case (ctl.mode)
			CM_NET: begin
				take_r = net_is_left(idx, ctl.split, ctl.cnt, ctl.rnd);
				take_l = (idx != '0) &&
					net_is_left(idx - CNT_W'(1), ctl.split, ctl.cnt, ctl.rnd);
			end
			CM_PAIR: begin
				take_r = (idx == ctl.sel);
				take_l = (idx == ctl.sel + CNT_W'(1));
			end
			default: begin
				take_l = 1'b0;
				take_r = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.mode == CM_APPEND && idx == ctl.sel) begin
			data_q <= ctl.value;
		end else if (take_r) begin
			data_q <= right_data;
		end else if (take_l) begin
			data_q <= left_data;
		end
	end

	// The read tap chain moves toward cell zero; the selected cell injects
	// its entry.
	always_ff @(posedge clk) begin
		if (ctl.mode == CM_READ) begin
			tap_q <= (idx == ctl.sel) ? data_q : tap_in;
		end
	end

	assign data = data_q;
	assign tap  = tap_q;

endmodule

`default_nettype wire

// ===== rtl/ape_ctrl.sv =====
// Sequencer: decodes a transaction, steps the cell row and holds the result.
`default_nettype none

module ape_ctrl (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	output logic                        in_ready,
	input  wire [ape_pkg::FUNC_W-1:0]   func,
	input  wire signed [ape_pkg::DATA_W-1:0] value,
	input  wire [ape_pkg::CNT_W-1:0]    position,
	output logic                        out_valid,
	input  wire                         out_ready,
	output logic signed [ape_pkg::DATA_W-1:0] read_value,
	output logic [ape_pkg::CNT_W-1:0]   fill_count,
	output logic [ape_pkg::STAT_W-1:0]  status,
	input  ape_pkg::word_t              tap_head,
	output ape_pkg::cell_ctl_t          ctl
);
	import ape_pkg::*;

	fsm_t       state_q, state_d;
	cnt_t       cnt_q;
	logic       out_valid_q;
	cell_mode_t mode_q, mode_d;
	cnt_t       sel_q, sel_d;
	cnt_t       split_q, split_d;
	cnt_t       round_q;
	cnt_t       left_q, rounds_d;
	word_t      value_q;
	status_t    op_status_q, status_d;
	logic       grow_q, grow_d;
	logic       read_q, read_d;
	word_t      read_value_q;
	cnt_t       fill_count_q;
	status_t    status_q;
	logic       accept;
	logic       run;
	logic       retire;
	cnt_t       high_len;

	// Decode of the incoming transaction against the current fill count.
	always_comb begin
		mode_d   = CM_HOLD;
		sel_d    = '0;
		split_d  = '0;
		rounds_d = '0;
		status_d = ST_OK;
		grow_d   = 1'b0;
		read_d   = 1'b0;
		high_len = cnt_q - position;
		case (func)
			FN_APPEND: begin
				if (cnt_q >= CNT_W'(DEPTH)) begin
					status_d = ST_FULL;
				end else begin
					mode_d   = CM_APPEND;
					sel_d    = cnt_q;
					rounds_d = CNT_W'(1);
					grow_d   = 1'b1;
				end
			end
			FN_REVERSE: begin
				mode_d   = CM_NET;
				rounds_d = cnt_q;
			end
			FN_PAIR: begin
				mode_d   = CM_NET;
				rounds_d = CNT_W'(1);
			end
			FN_ROTATE: begin
				if (cnt_q >= CNT_W'(2)) begin
					mode_d   = CM_PAIR;
					sel_d    = cnt_q - CNT_W'(2);
					rounds_d = cnt_q - CNT_W'(1);
				end
			end
			FN_SPLIT: begin
				if (position > cnt_q) begin
					status_d = ST_BAD_SPLIT;
				end else begin
					mode_d   = CM_NET;
					split_d  = position;
					rounds_d = (position > high_len) ? position : high_len;
				end
			end
			FN_READ: begin
				if (position >= cnt_q) begin
					status_d = ST_BAD_INDEX;
				end else begin
					mode_d   = CM_READ;
					sel_d    = position;
					rounds_d = position + CNT_W'(1);
					read_d   = 1'b1;
				end
			end
			default: begin
				mode_d = CM_HOLD;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (in_valid) begin
					state_d = (rounds_d == '0) ? FSM_FINISH : FSM_RUN;
				end
			end
			FSM_RUN: begin
				if (left_q == CNT_W'(1)) begin
					state_d = FSM_FINISH;
				end
			end
			FSM_FINISH: begin
				if (!out_valid_q || out_ready) begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		run      = 1'b0;
		retire   = 1'b0;
		case (state_q)
			FSM_IDLE:   in_ready = 1'b1;
			FSM_RUN:    run      = 1'b1;
			FSM_FINISH: retire   = !out_valid_q || out_ready;
			default:    in_ready = 1'b0;
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (retire) begin
				cnt_q       <= cnt_q + CNT_W'(grow_q);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q      <= mode_d;
			sel_q       <= sel_d;
			split_q     <= split_d;
			round_q     <= '0;
			left_q      <= rounds_d;
			value_q     <= value;
			op_status_q <= status_d;
			grow_q      <= grow_d;
			read_q      <= read_d;
		end else if (run) begin
			round_q <= round_q + CNT_W'(1);
			left_q  <= left_q - CNT_W'(1);
			if (mode_q == CM_PAIR) begin
				sel_q <= sel_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (retire) begin
			read_value_q <= read_q ? tap_head : '0;
			fill_count_q <= cnt_q + CNT_W'(grow_q);
			status_q     <= op_status_q;
		end
	end

	always_comb begin
		ctl.mode  = run ? mode_q : CM_HOLD;
		ctl.cnt   = cnt_q;
		ctl.split = split_q;
		ctl.rnd   = round_q;
		ctl.sel   = sel_q;
		ctl.value = value_q;
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign fill_count = fill_count_q;
	assign status     = status_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("fill count above depth");

	a_cnt_at_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |-> ($past(state_q) == FSM_FINISH))
		else $error("fill count changed outside a finish");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |-> (cnt_q == $past(cnt_q) + CNT_W'(1)))
		else $error("fill count moved by other than one");

	a_valid_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == FSM_FINISH))
		else $error("result raised without a finish");

	a_run_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_RUN) |-> (left_q != '0))
		else $error("running with no rounds left");

endmodule

`default_nettype wire
